FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: design/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// shared types and constants of the lru key-value cache
// ----------------------------------------------------------------------------
package lkv_pkg;

    // number of cells in the recency chain
    localparam int MAX_ENTRIES = 16;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CFG_W = 5;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

    // operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // request transaction
    typedef struct packed {
        logic                    operation;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_lkv_in;

    // response transaction
    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
    } t_lkv_out;

    // one stored entry, also what a cell hands to its neighbor
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_lkv_entry;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic lookup;
        logic update;
        logic put;
        logic active;
    } t_lkv_ctrl;

endpackage

FILE: design/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// Requests enter on i_in (operation, key, value) with i_in_valid / o_in_stall.
// A get returns one transaction on o_out (hit, read_value) with o_out_valid /
// i_out_stall; a miss returns hit low and read_value all ones. A put returns
// nothing. Capacity is written on i_cfg_data with i_cfg_valid / o_cfg_ready,
// ready is always high; write it only while the cache is idle.
// A request is accepted in ST_IDLE: the accept edge loads the compare result
// into every cell, then the update in ST_UPDATE shifts the recency chain.
// A new request is accepted only once the previous one has shifted the chain;
// the chain of cells is the limit, since the compare for a request must see
// the entries the previous one left. A get result is registered at the update.
// When a get result is due while the output register is full and stalled,
// the update waits and o_in_stall stays high until the register drains.
// Reset (synchronous, active low) clears all entries and sets capacity to
// 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  lkv_pkg::t_lkv_in                 i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output lkv_pkg::t_lkv_out                o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lkv_pkg::CFG_W-1:0]        i_cfg_data
);
    import lkv_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic                    r_state;
    logic                    n_state;
    t_lkv_in                 r_req;
    logic [CFG_W-1:0]        r_cap;
    logic                    r_out_valid;
    t_lkv_out                r_out;

    logic                    w_accept;
    logic                    w_go;
    logic [CMP_W-1:0]        w_cap_eff;
    logic [MAX_ENTRIES-1:0]  w_keep;
    t_lkv_ctrl               w_ctrl;
    t_lkv_entry              w_head;
    t_lkv_entry              w_chain [MAX_ENTRIES+1];
    logic                    w_found [MAX_ENTRIES+1];
    logic signed [VAL_W-1:0] w_sel   [MAX_ENTRIES+1];

    // handshakes
    assign o_in_stall  = (r_state == ST_UPDATE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_go        = !((r_req.operation == OP_GET) && r_out_valid && i_out_stall);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_accept) n_state = ST_UPDATE;
            ST_UPDATE: if (w_go) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in;
        end
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    // capacity clamped to one .. MAX_ENTRIES
    always_comb begin
        priority if (r_cap == '0) begin
            w_cap_eff = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(MAX_ENTRIES)) begin
            w_cap_eff = CMP_W'(MAX_ENTRIES);
        end else begin
            w_cap_eff = CMP_W'(r_cap);
        end
    end

    // slots below the capacity survive a put
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_keep[i] = (CMP_W'(i) < w_cap_eff);
        end
    end

    // broadcast control
    assign w_ctrl.lookup = w_accept;
    assign w_ctrl.update = (r_state == ST_UPDATE) && w_go;
    assign w_ctrl.put    = (r_req.operation == OP_PUT);
    assign w_ctrl.active = (r_req.operation == OP_PUT) || w_found[MAX_ENTRIES];

    // new most recently used entry fed into the head of the chain
    assign w_head.valid = 1'b1;
    assign w_head.key   = r_req.key;
    assign w_head.value = (r_req.operation == OP_PUT) ? r_req.value : w_sel[MAX_ENTRIES];

    assign w_chain[0] = w_head;
    assign w_found[0] = 1'b0;
    assign w_sel[0]   = '0;

    // recency chain, slot 0 is most recently used
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        lkv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_key   (i_in.key),
            .i_keep  (w_keep[g]),
            .i_prev  (w_chain[g]),
            .o_entry (w_chain[g+1]),
            .i_found (w_found[g]),
            .o_found (w_found[g+1]),
            .i_sel   (w_sel[g]),
            .o_sel   (w_sel[g+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.update && (r_req.operation == OP_GET)) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.update && (r_req.operation == OP_GET)) begin
            r_out.hit        <= w_found[MAX_ENTRIES];
            r_out.read_value <= w_found[MAX_ENTRIES] ? w_sel[MAX_ENTRIES] : '1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: design/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell
// one slot of the recency chain: holds an entry, compares it against the
// lookup key and takes its neighbor's entry when the chain shifts
// ----------------------------------------------------------------------------
module lkv_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lkv_pkg::t_lkv_ctrl                i_ctrl,
    input  logic signed [lkv_pkg::KEY_W-1:0]  i_key,
    input  logic                              i_keep,
    input  lkv_pkg::t_lkv_entry               i_prev,
    output lkv_pkg::t_lkv_entry               o_entry,
    input  logic                              i_found,
    output logic                              o_found,
    input  logic signed [lkv_pkg::VAL_W-1:0]  i_sel,
    output logic signed [lkv_pkg::VAL_W-1:0]  o_sel
);
    import lkv_pkg::*;

    logic                    r_valid;
    logic                    r_match;
    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_value;
    logic                    w_shift;

    // slots up to and including the hit slot take the neighbor's entry
    assign w_shift = i_ctrl.update && i_ctrl.active && !i_found;

    // valid and match flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctrl.lookup) begin
                r_match <= r_valid && (r_key == i_key);
            end
            if (w_shift) begin
                r_valid <= i_prev.valid;
            end
            // a put trims the chain to the capacity
            if (i_ctrl.update && i_ctrl.put && !i_keep) begin
                r_valid <= 1'b0;
            end
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key   <= i_prev.key;
            r_value <= i_prev.value;
        end
    end

    // hit chain and one-hot value select
    assign o_found = i_found || r_match;
    assign o_sel   = i_sel | (r_match ? r_value : '0);

    assign o_entry.valid = r_valid;
    assign o_entry.key   = r_key;
    assign o_entry.value = r_value;

endmodule

FILE: design/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker
// port-level checks of the lru key-value cache, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lkv_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_stall,
    input  lkv_pkg::t_lkv_in   i_in,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  lkv_pkg::t_lkv_out  o_out
);
    import lkv_pkg::*;

    // a stalled response transaction stays offered
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // a miss always reads back all ones
    `ASSERT_SAME(a_miss_value, i_clk, i_rst_n, o_out_valid && !o_out.hit, o_out.read_value == '1)

    // the request-side stall is gone in the next cycle unless a response is blocked
    `ASSERT_NEXT(a_stall_short, i_clk, i_rst_n, o_in_stall && !(o_out_valid && i_out_stall), !o_in_stall)

    // a put into an idle cache gives no response
    `ASSERT_NEXT(a_put_silent, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_in.operation == OP_PUT) && !o_out_valid, !o_out_valid ##1 !o_out_valid)

endmodule

bind lru_key_value_cache_core lkv_checker u_lkv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

FILE: verif/tb_lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_core
// self-checking bench for the lru key-value cache core
// ----------------------------------------------------------------------------
// A shadow copy of the recency-ordered store tracks every accepted request and
// queues the expected get response. A checker compares each response against
// the oldest queued one. Directed tests cover the empty store, key and value
// extremes, update of a present key, capacity 0 and 1, and a capacity lowered
// below the fill. Random phases then sweep capacity settings with small key
// pools so that hits, misses, updates and evictions all occur, with random
// gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_core;
    import lkv_pkg::*;

    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_ITEMS    = 160;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    t_lkv_in                i_in        = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_lkv_out               o_out;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data  = '0;

    // shadow store, slot 0 is most recently used
    logic signed [KEY_W-1:0] shadow_key [MAX_ENTRIES];
    logic signed [VAL_W-1:0] shadow_val [MAX_ENTRIES];
    bit                      shadow_vld [MAX_ENTRIES];
    logic [CFG_W-1:0]        shadow_cap;

    t_lkv_out pending_reads[$];
    int       error_count = 0;
    int       idle_cycles = 0;
    int       stall_left  = 0;
    bit       in_gaps_on  = 1'b0;
    bit       out_stall_on = 1'b0;

    wire in_fire  = i_in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !i_out_stall;
    wire cfg_fire = i_cfg_valid && o_cfg_ready;

    lru_key_value_cache_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // shadow store
    // ------------------------------------------------------------------------

    // remove one slot and close the gap
    function automatic void drop_slot(input int pos);
        for (int i = pos; i < MAX_ENTRIES - 1; i++) begin
            shadow_key[i] = shadow_key[i + 1];
            shadow_val[i] = shadow_val[i + 1];
            shadow_vld[i] = shadow_vld[i + 1];
        end
        shadow_vld[MAX_ENTRIES - 1] = 1'b0;
    endfunction

    // shift everything down and place the entry as most recently used
    function automatic void place_front(input logic signed [KEY_W-1:0] k,
                                        input logic signed [VAL_W-1:0] v);
        for (int i = MAX_ENTRIES - 1; i > 0; i--) begin
            shadow_key[i] = shadow_key[i - 1];
            shadow_val[i] = shadow_val[i - 1];
            shadow_vld[i] = shadow_vld[i - 1];
        end
        shadow_key[0] = k;
        shadow_val[0] = v;
        shadow_vld[0] = 1'b1;
    endfunction

    function automatic int usable_capacity(input logic [CFG_W-1:0] cap);
        if (cap == 0)
            return 1;
        if (cap > MAX_ENTRIES)
            return MAX_ENTRIES;
        return int'(cap);
    endfunction

    // update the shadow store for one request, queue the get response
    function automatic void apply_request(input t_lkv_in req);
        int                      pos;
        int                      fill;
        int                      limit;
        t_lkv_out                rsp;
        logic signed [VAL_W-1:0] v;
        pos = -1;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (pos < 0 && shadow_vld[i] && shadow_key[i] == req.key)
                pos = i;
        if (req.operation == OP_GET) begin
            rsp.hit        = (pos >= 0);
            rsp.read_value = '1;
            if (pos >= 0) begin
                v = shadow_val[pos];
                rsp.read_value = v;
                drop_slot(pos);
                place_front(req.key, v);
            end
            pending_reads.push_back(rsp);
        end else begin
            if (pos >= 0)
                drop_slot(pos);
            limit = usable_capacity(shadow_cap);
            fill  = 0;
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (shadow_vld[i])
                    fill++;
            // evict from the least recently used end until there is room
            while (fill >= limit && fill > 0) begin
                drop_slot(fill - 1);
                fill--;
            end
            place_front(req.key, req.value);
        end
    endfunction

    // track accepted config writes and requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ENTRIES; i++)
                shadow_vld[i] = 1'b0;
            shadow_cap = CAP_RESET;
        end else begin
            if (cfg_fire)
                shadow_cap = i_cfg_data;
            if (in_fire)
                apply_request(i_in);
        end
    end

    // ------------------------------------------------------------------------
    // response checking
    // ------------------------------------------------------------------------

    function automatic void log_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endfunction

    always @(posedge i_clk) begin : check_responses
        t_lkv_out want;
        if (i_rst_n && out_fire) begin
            if (pending_reads.size() == 0) begin
                log_error($sformatf("unexpected response: hit=%0b read_value=%0d",
                                    o_out.hit, o_out.read_value));
            end else begin
                want = pending_reads.pop_front();
                if (o_out.hit !== want.hit || o_out.read_value !== want.read_value)
                    log_error($sformatf(
                        "mismatch: expected hit=%0b read_value=%0d, got hit=%0b read_value=%0d",
                        want.hit, want.read_value, o_out.hit, o_out.read_value));
            end
        end
    end

    // ------------------------------------------------------------------------
    // idling and watchdog
    // ------------------------------------------------------------------------

    // mostly short idle stretches, a few long ones
    function automatic int pick_idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // response-side stall
    always @(posedge i_clk) begin
        if (!i_rst_n || !out_stall_on) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < 30) begin
            stall_left = pick_idle_len() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire || cfg_fire) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------------

    // one request transaction, returns at the edge that accepts it
    task automatic send_request(input logic                    op,
                                input logic signed [KEY_W-1:0] k,
                                input logic signed [VAL_W-1:0] v);
        int gap;
        gap = (in_gaps_on && $urandom_range(0, 99) < 40) ? pick_idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= '{operation: op, key: k, value: v};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop requests and let every outstanding response arrive
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reads.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // empty store, key and value extremes, update of a present key
    task automatic test_extremes_and_update();
        send_request(OP_GET, 32'sd0, 32'sd0);
        send_request(OP_PUT, 32'sh7FFFFFFF, 32'sh80000000);
        send_request(OP_PUT, 32'sh80000000, 32'sh7FFFFFFF);
        send_request(OP_PUT, 32'sd0, 32'sd0);
        send_request(OP_PUT, -32'sd1, -32'sd1);
        send_request(OP_GET, 32'sh7FFFFFFF, 32'sh5A5A5A5A);
        send_request(OP_GET, 32'sh80000000, -32'sd1);
        send_request(OP_GET, 32'sd0, 32'sh7FFFFFFF);
        send_request(OP_GET, -32'sd1, 32'sh80000000);
        send_request(OP_GET, 32'sh12345678, 32'sd0);
        send_request(OP_PUT, -32'sd1, 32'sh0BADCAFE);
        send_request(OP_GET, -32'sd1, 32'sd0);
    endtask

    // capacity one evicts on every new key, zero acts as one
    task automatic test_capacity_one_and_zero();
        write_capacity(1);
        send_request(OP_PUT, 32'sd11, 32'sd110);
        send_request(OP_PUT, 32'sd22, 32'sd220);
        send_request(OP_GET, 32'sd11, 32'sd0);
        send_request(OP_GET, 32'sd22, 32'sd0);
        write_capacity(0);
        send_request(OP_PUT, 32'sd33, 32'sd330);
        send_request(OP_GET, 32'sd22, 32'sd0);
        send_request(OP_GET, 32'sd33, 32'sd0);
    endtask

    // entries beyond a lowered capacity stay readable until the next insert
    task automatic test_capacity_lowered();
        write_capacity(4);
        send_request(OP_PUT, 32'sd101, 32'sd1);
        send_request(OP_PUT, 32'sd102, 32'sd2);
        send_request(OP_PUT, 32'sd103, 32'sd3);
        send_request(OP_PUT, 32'sd104, 32'sd4);
        write_capacity(2);
        send_request(OP_GET, 32'sd101, 32'sd0);
        send_request(OP_PUT, 32'sd105, 32'sd5);
        send_request(OP_GET, 32'sd104, 32'sd0);
        send_request(OP_GET, 32'sd101, 32'sd0);
    endtask

    // random gets and puts over small key pools across capacity settings
    task automatic test_random_traffic();
        logic [CFG_W-1:0]        cap_plan [8] = '{16, 31, 1, 0, 17, 5, 2, 8};
        logic signed [KEY_W-1:0] key_pool [24];
        logic signed [KEY_W-1:0] extremes [4] = '{32'sh0, -32'sh1, 32'sh80000000,
                                                 32'sh7FFFFFFF};
        logic [CFG_W-1:0]        cap;
        logic signed [KEY_W-1:0] k;
        logic signed [VAL_W-1:0] v;
        int                      pool_size;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            cap = (ph < 8) ? cap_plan[ph] : CFG_W'($urandom_range(0, 31));
            write_capacity(cap);
            // idling pattern per phase, every fourth phase runs flat out
            in_gaps_on   = ph[0];
            out_stall_on = ph[1];
            pool_size = usable_capacity(cap) + $urandom_range(1, 6);
            for (int i = 0; i < pool_size; i++)
                key_pool[i] = ($urandom_range(0, 9) == 0) ? extremes[$urandom_range(0, 3)]
                                                          : $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                k = ($urandom_range(0, 19) == 0) ? $urandom
                                                 : key_pool[$urandom_range(0, pool_size - 1)];
                v = ($urandom_range(0, 9) == 0) ? extremes[$urandom_range(0, 3)] : $urandom;
                send_request($urandom_range(0, 1) ? OP_PUT : OP_GET, k, v);
            end
        end
        in_gaps_on   = 1'b0;
        out_stall_on = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes_and_update();
        test_capacity_one_and_zero();
        test_capacity_lowered();
        test_random_traffic();
        wait_idle();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
